// File: src/hcbd_pkg.sv
package hcbd_pkg;

  // Default width of the chunk size and byte counter.
  localparam int unsigned CountBitsDef = 32;

  // Both internal queues hold two entries.
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QueuePtrBits = 1;
  localparam int unsigned QueueCntBits = 2;

  // Characters with a framing meaning.
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;

  // Class of one body byte, as the size line parser sees it.
  typedef enum logic [2:0] {
    CLS_LF    = 3'd0,
    CLS_CR    = 3'd1,
    CLS_BLANK = 3'd2,
    CLS_HEX   = 3'd3,
    CLS_OTHER = 3'd4
  } char_class_e;

  // One classified request, passed from the front part to the back part.
  typedef struct packed {
    logic        restart;
    char_class_e cls;
    logic [3:0]  digit;
    logic [7:0]  data;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       body_end;
    logic       size_overflow;
  } result_t;

  // Decoder phase, one-hot.
  typedef enum logic [4:0] {
    PH_SIZE   = 5'b00001,
    PH_DATA   = 5'b00010,
    PH_TRAIL1 = 5'b00100,
    PH_TRAIL2 = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

endpackage

// File: src/hcbd_fifo.sv
module hcbd_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_pop_i,
  output logic [Width-1:0] rd_data_o,
  output logic             empty_o
);

  logic [Width-1:0]                     mem_q [hcbd_pkg::QueueDepth];
  logic [hcbd_pkg::QueuePtrBits-1:0]    wr_ptr_q, wr_ptr_d;
  logic [hcbd_pkg::QueuePtrBits-1:0]    rd_ptr_q, rd_ptr_d;
  logic [hcbd_pkg::QueueCntBits-1:0]    cnt_q, cnt_d;
  logic                                 do_wr, do_rd;

  // Handshake decode.
  assign full_o  = (cnt_q == hcbd_pkg::QueueCntBits'(hcbd_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_valid_i && !full_o;
  assign do_rd   = rd_pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_ptr_q];

endmodule

// File: src/hcbd_front.sv
module hcbd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              action_i,
  input  logic [7:0]        data_byte_i,
  input  logic              cmd_pop_i,
  output hcbd_pkg::cmd_t    cmd_o,
  output logic              cmd_empty_o
);

  hcbd_pkg::cmd_t cmd_in;
  logic [$bits(hcbd_pkg::cmd_t)-1:0] cmd_rd;

  // Classify the incoming byte for the size line parser.
  always_comb begin
    cmd_in.restart = action_i;
    cmd_in.data    = data_byte_i;
    cmd_in.digit   = '0;
    cmd_in.cls     = hcbd_pkg::CLS_OTHER;
    if (data_byte_i == hcbd_pkg::CharLf) begin
      cmd_in.cls = hcbd_pkg::CLS_LF;
    end else if (data_byte_i == hcbd_pkg::CharCr) begin
      cmd_in.cls = hcbd_pkg::CLS_CR;
    end else if (data_byte_i == hcbd_pkg::CharSpace || data_byte_i == hcbd_pkg::CharTab) begin
      cmd_in.cls = hcbd_pkg::CLS_BLANK;
    end else if (data_byte_i >= "0" && data_byte_i <= "9") begin
      cmd_in.cls   = hcbd_pkg::CLS_HEX;
      cmd_in.digit = 4'(data_byte_i - 8'("0"));
    end else if (data_byte_i >= "a" && data_byte_i <= "f") begin
      cmd_in.cls   = hcbd_pkg::CLS_HEX;
      cmd_in.digit = 4'(data_byte_i - 8'("a") + 8'd10);
    end else if (data_byte_i >= "A" && data_byte_i <= "F") begin
      cmd_in.cls   = hcbd_pkg::CLS_HEX;
      cmd_in.digit = 4'(data_byte_i - 8'("A") + 8'd10);
    end
  end

  // Short queue toward the back part.
  hcbd_fifo #(
    .Width($bits(hcbd_pkg::cmd_t))
  ) u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push),
    .wr_data_i  (cmd_in),
    .full_o     (full),
    .rd_pop_i   (cmd_pop_i),
    .rd_data_o  (cmd_rd),
    .empty_o    (cmd_empty_o)
  );

  assign cmd_o = hcbd_pkg::cmd_t'(cmd_rd);

endmodule

// File: src/hcbd_back.sv
module hcbd_back #(
  parameter int unsigned CountBits = hcbd_pkg::CountBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hcbd_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     payload_byte_o,
  output logic           payload_valid_o,
  output logic           body_end_o,
  output logic           size_overflow_o
);

  hcbd_pkg::phase_e       phase_q, phase_d;
  logic [CountBits-1:0]   count_q, count_d;
  logic [CountBits-1:0]   count_dec;
  logic                   ended_q, ended_d;
  logic                   digit_q, digit_d;
  logic                   ovf_q, ovf_d;
  hcbd_pkg::result_t      res;
  logic [$bits(hcbd_pkg::result_t)-1:0] res_rd;
  hcbd_pkg::result_t      res_out;
  logic                   res_full;
  logic                   take;

  // A request is carried out when the result queue has room.
  assign take      = !cmd_empty_i && !res_full;
  assign cmd_pop_o = take;
  assign count_dec = (count_q == '0) ? '0 : count_q - 1'b1;

  // Decoder step.
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    ended_d = ended_q;
    digit_d = digit_q;
    ovf_d   = ovf_q;
    res     = '0;
    if (cmd_i.restart) begin
      phase_d = hcbd_pkg::PH_SIZE;
      count_d = '0;
      ended_d = 1'b0;
      digit_d = 1'b0;
      ovf_d   = 1'b0;
    end else begin
      case (phase_q)
        hcbd_pkg::PH_SIZE: begin
          if (cmd_i.cls == hcbd_pkg::CLS_LF) begin
            res.size_overflow = ovf_q;
            if (count_q == '0) begin
              res.body_end = 1'b1;
              phase_d      = hcbd_pkg::PH_DONE;
            end else begin
              phase_d = hcbd_pkg::PH_DATA;
            end
            ended_d = 1'b0;
            digit_d = 1'b0;
            ovf_d   = 1'b0;
          end else if (cmd_i.cls == hcbd_pkg::CLS_CR || ended_q) begin
            // Dropped, or past the end of the number.
          end else if (!digit_q && cmd_i.cls == hcbd_pkg::CLS_BLANK) begin
            // Leading blank.
          end else if (cmd_i.cls == hcbd_pkg::CLS_HEX) begin
            // Accumulate a digit, saturating when the top nibble is in use.
            if (count_q[CountBits-1 -: 4] != '0) begin
              count_d = '1;
              ovf_d   = 1'b1;
            end else begin
              count_d = {count_q[CountBits-5:0], cmd_i.digit};
            end
            digit_d = 1'b1;
          end else begin
            ended_d = 1'b1;
          end
        end
        hcbd_pkg::PH_DATA: begin
          res.payload_byte  = cmd_i.data;
          res.payload_valid = 1'b1;
          count_d           = count_dec;
          if (count_dec == '0) begin
            phase_d = hcbd_pkg::PH_TRAIL1;
          end
        end
        hcbd_pkg::PH_TRAIL1: begin
          phase_d = hcbd_pkg::PH_TRAIL2;
        end
        hcbd_pkg::PH_TRAIL2: begin
          phase_d = hcbd_pkg::PH_SIZE;
          count_d = '0;
          ended_d = 1'b0;
          digit_d = 1'b0;
          ovf_d   = 1'b0;
        end
        default: begin
          // Done: bytes are ignored until a restart.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hcbd_pkg::PH_SIZE;
      count_q <= '0;
      ended_q <= 1'b0;
      digit_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (take) begin
      phase_q <= phase_d;
      count_q <= count_d;
      ended_q <= ended_d;
      digit_q <= digit_d;
      ovf_q   <= ovf_d;
    end
  end

  // Result queue toward the consumer.
  hcbd_fifo #(
    .Width($bits(hcbd_pkg::result_t))
  ) u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (take),
    .wr_data_i  (res),
    .full_o     (res_full),
    .rd_pop_i   (pop),
    .rd_data_o  (res_rd),
    .empty_o    (empty)
  );

  assign res_out         = hcbd_pkg::result_t'(res_rd);
  assign payload_byte_o  = res_out.payload_byte;
  assign payload_valid_o = res_out.payload_valid;
  assign body_end_o      = res_out.body_end;
  assign size_overflow_o = res_out.size_overflow;

  // A result never carries payload and the end of the body together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> !(res.payload_valid && res.body_end))
    else $error("payload and body end in one result");

  // An overflow flag is reported only on the LF of a size line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && res.size_overflow) |->
      (phase_q == hcbd_pkg::PH_SIZE && cmd_i.cls == hcbd_pkg::CLS_LF && !cmd_i.restart))
    else $error("overflow flag outside a size line end");

  // A restart leaves a cleared parser expecting a size line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && cmd_i.restart) |=>
      (phase_q == hcbd_pkg::PH_SIZE && count_q == '0 && !ovf_q && !digit_q && !ended_q))
    else $error("restart did not clear the parser");

  // Once done, ordinary bytes give empty results and leave the phase alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !cmd_i.restart && phase_q == hcbd_pkg::PH_DONE) |->
      (res == '0 && phase_d == hcbd_pkg::PH_DONE))
    else $error("activity after end of body");

  // The payload countdown never runs out while still in the payload phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == hcbd_pkg::PH_DATA) |-> (count_q != '0))
    else $error("payload phase with zero count");

endmodule

// File: src/http_chunked_body_decoder_top.sv
// Chunked body decoder: one byte request in, one result request out.
// Path: a pushed byte is written into the command queue, then the parser step writes its result into the result queue.
// Throughput: one byte per cycle while the consumer pops; a full result queue stalls the parser step in the back part.
// Two-entry queues sit between the input, parser and output, so each side stalls alone.
// Reset (rst_ni low, asynchronous) empties both queues and sets the parser to expect a size line.
module http_chunked_body_decoder_top #(
  parameter int unsigned CountBits = hcbd_pkg::CountBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       action_i,
  input  logic [7:0] data_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] payload_byte_o,
  output logic       payload_valid_o,
  output logic       body_end_o,
  output logic       size_overflow_o
);

  hcbd_pkg::cmd_t cmd;
  logic           cmd_empty;
  logic           cmd_pop;

  // Front part: classify each byte and queue it.
  hcbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .action_i    (action_i),
    .data_byte_i (data_byte_i),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty)
  );

  // Back part: framing state machine and result queue.
  hcbd_back #(
    .CountBits(CountBits)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cmd_empty_i     (cmd_empty),
    .cmd_pop_o       (cmd_pop),
    .pop             (pop),
    .empty           (empty),
    .payload_byte_o  (payload_byte_o),
    .payload_valid_o (payload_valid_o),
    .body_end_o      (body_end_o),
    .size_overflow_o (size_overflow_o)
  );

endmodule
